// File: rtl/sgtr_pkg.sv
// ----------------------------------------------------------------------------
// Glyph rasterizer package
// Shared widths, sequencer types and the 5x7 font ROM.
// ----------------------------------------------------------------------------
package sgtr_pkg;

  localparam int CODE_W  = 8;
  localparam int INK_W   = 24;
  localparam int SCALE_W = 6;
  localparam int ADV_W   = SCALE_W + 3;
  localparam int ROWS    = 7;
  localparam int COLS    = 5;
  localparam int DOTS    = ROWS * COLS;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLS);

  typedef logic [DOTS-1:0] dot_mask_t;
  typedef logic [0:ROWS-1][COLS-1:0] glyph_rows_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROW,
    ST_ADV
  } seq_state_t;

  typedef enum logic [1:0] {
    OP_COL,
    OP_ROW,
    OP_CUR
  } add_op_t;

  typedef struct packed {
    logic accept;
    logic skip;
    logic slot_free;
  } seq_stat_t;

  typedef struct packed {
    logic    in_ready;
    logic    step;
    add_op_t op;
    logic    row_adv;
    logic    cursor_upd;
  } seq_ctrl_t;

  function automatic glyph_rows_t font_rows(input logic [CODE_W-1:0] code);
    glyph_rows_t r;
    case (code)
      "0": r = {5'h1E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h1E};
      "1": r = {5'h04, 5'h0C, 5'h14, 5'h04, 5'h04, 5'h04, 5'h1F};
      "2": r = {5'h1E, 5'h01, 5'h01, 5'h1E, 5'h10, 5'h10, 5'h1F};
      "3": r = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "4": r = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      "5": r = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      "6": r = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h1E};
      "7": r = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      "8": r = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      "9": r = {5'h1E, 5'h11, 5'h11, 5'h1F, 5'h01, 5'h01, 5'h1E};
      "P": r = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      "A": r = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      "I": r = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      "L": r = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      "U": r = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      "S": r = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      "E": r = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      "R": r = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h12, 5'h11, 5'h11};
      "G": r = {5'h0E, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
      "M": r = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11};
      "O": r = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      "V": r = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04};
      "W": r = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
      "D": r = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      "J": r = {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
      "K": r = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      "/": r = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00};
      "Q": r = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      ":": r = {5'h00, 5'h04, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Dot (row, col) lands at bit row*COLS + col; column 0 is the row's MSB.
  function automatic dot_mask_t font_mask(input logic [CODE_W-1:0] code);
    glyph_rows_t r;
    dot_mask_t   m;
    r = font_rows(code);
    for (int row = 0; row < ROWS; row++) begin
      for (int col = 0; col < COLS; col++) begin
        m[row*COLS + col] = r[row][COLS-1-col];
      end
    end
    return m;
  endfunction

endpackage

// File: rtl/sgtr_in_if.sv
// ----------------------------------------------------------------------------
// Character input channel
// Valid/ready channel carrying one text character per transaction.
// ----------------------------------------------------------------------------
interface sgtr_in_if #(
  parameter int COORD_BITS = 16
);
  import sgtr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CODE_W-1:0]     char_code;
  logic                  first_of_text;
  logic [COORD_BITS-1:0] origin_x;
  logic [COORD_BITS-1:0] origin_y;
  logic [INK_W-1:0]      ink_color;
  logic [SCALE_W-1:0]    pixel_scale;

  modport source (
    output valid, char_code, first_of_text, origin_x, origin_y, ink_color, pixel_scale,
    input  ready
  );

  modport sink (
    input  valid, char_code, first_of_text, origin_x, origin_y, ink_color, pixel_scale,
    output ready
  );

endinterface

// File: rtl/sgtr_out_if.sv
// ----------------------------------------------------------------------------
// Square fill output channel
// Valid/ready channel carrying one square fill command per transaction.
// ----------------------------------------------------------------------------
interface sgtr_out_if #(
  parameter int COORD_BITS = 16
);
  import sgtr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] rect_x;
  logic [COORD_BITS-1:0] rect_y;
  logic [SCALE_W-1:0]    rect_side;
  logic [INK_W-1:0]      rect_color;
  logic                  last_of_char;

  modport source (
    output valid, rect_x, rect_y, rect_side, rect_color, last_of_char,
    input  ready
  );

  modport sink (
    input  valid, rect_x, rect_y, rect_side, rect_color, last_of_char,
    output ready
  );

endinterface

// File: rtl/sgtr_sat_add.sv
// ----------------------------------------------------------------------------
// Saturating coordinate adder
// Adds a small step to a coordinate and clamps the sum at full scale.
// ----------------------------------------------------------------------------
module sgtr_sat_add #(
  parameter int COORD_BITS = 16
) (
  input  logic [COORD_BITS-1:0]    a,
  input  logic [sgtr_pkg::ADV_W-1:0] b,
  output logic [COORD_BITS-1:0]    sum
);
  import sgtr_pkg::*;

  localparam int SUM_W = COORD_BITS + ADV_W + 1;

  logic [SUM_W-1:0] wide;

  assign wide = SUM_W'(a) + SUM_W'(b);
  assign sum  = (|wide[SUM_W-1:COORD_BITS]) ? '1 : wide[COORD_BITS-1:0];

endmodule

// File: rtl/sgtr_seq.sv
// ----------------------------------------------------------------------------
// Glyph scan sequencer
// Walks the 7x5 dot grid and schedules the shared adder.
// ----------------------------------------------------------------------------
module sgtr_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  sgtr_pkg::seq_stat_t stat,
  output sgtr_pkg::seq_ctrl_t ctrl
);
  import sgtr_pkg::*;

  seq_state_t       state_r, state_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             col_last;
  logic             row_last;

  assign col_last = (col_r == COL_W'(COLS - 1));
  assign row_last = (row_r == ROW_W'(ROWS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (stat.accept) begin
          state_nxt = stat.skip ? ST_ADV : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.slot_free && col_last) begin
          state_nxt = row_last ? ST_ADV : ST_ROW;
        end
      end
      ST_ROW:  state_nxt = ST_SCAN;
      ST_ADV:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.op = OP_COL;
    case (state_r)
      ST_IDLE: ctrl.in_ready = 1'b1;
      ST_SCAN: ctrl.step = stat.slot_free;
      ST_ROW: begin
        ctrl.op      = OP_ROW;
        ctrl.row_adv = 1'b1;
      end
      ST_ADV: begin
        ctrl.op         = OP_CUR;
        ctrl.cursor_upd = 1'b1;
      end
      default: ctrl = '0;
    endcase
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (stat.accept) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (ctrl.step) begin
      col_nxt = col_last ? '0 : col_r + COL_W'(1);
    end else if (ctrl.row_adv) begin
      row_nxt = row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

endmodule

// File: rtl/scaled_glyph_text_rasterizer.sv
// ----------------------------------------------------------------------------
// Scaled glyph text rasterizer
// Turns text characters into square fill commands from a 5x7 font.
// ----------------------------------------------------------------------------
// Each input transaction carries one character with its origin, ink color,
// dot scale and a flag that starts a new string. The block looks the code up
// in its font ROM and emits one square per set dot, row by row and left to
// right, on the output channel; last_of_char marks the final square.
// Unknown codes, the space and scale zero emit nothing but still move the
// cursor, which then advances by six dots.
// A character that draws dots passes through the accepting cycle, 35 dot
// steps and 6 row steps through the single saturating adder, then one
// cursor update; a character that draws nothing goes from the accepting
// cycle straight to the cursor update.
// The input is not ready until the cursor update is done. A stalled
// output holds its square and freezes the dot scan until the square is
// taken. Reset clears the cursor to zero and empties the output register.
// ----------------------------------------------------------------------------
module scaled_glyph_text_rasterizer #(
  parameter int COORD_BITS = 16
) (
  input logic         clk,
  input logic         rst_n,
  sgtr_in_if.sink     in_ch,
  sgtr_out_if.source  out_ch
);
  import sgtr_pkg::*;

  seq_stat_t stat;
  seq_ctrl_t ctrl;

  logic [COORD_BITS-1:0] cursor_r, cursor_nxt;
  logic [COORD_BITS-1:0] x_acc_r, x_acc_nxt;
  logic [COORD_BITS-1:0] y_acc_r, y_acc_nxt;
  dot_mask_t             rem_r, rem_nxt;
  logic [SCALE_W-1:0]    side_r;
  logic [INK_W-1:0]      color_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic [SCALE_W-1:0]    out_side_r;
  logic [INK_W-1:0]      out_color_r;
  logic                  out_last_r;

  logic [COORD_BITS-1:0] add_a;
  logic [ADV_W-1:0]      add_b;
  logic [COORD_BITS-1:0] add_sum;
  logic [ADV_W-1:0]      advance;
  logic [COORD_BITS-1:0] start_x;
  dot_mask_t             glyph_mask;
  logic                  emit;

  assign stat.accept    = in_ch.valid && ctrl.in_ready;
  assign stat.slot_free = !out_valid_r || out_ch.ready;
  assign glyph_mask     = font_mask(in_ch.char_code);
  assign stat.skip      = (glyph_mask == '0) || (in_ch.pixel_scale == '0);

  sgtr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  assign advance = (ADV_W'(side_r) << 2) + (ADV_W'(side_r) << 1);

  always_comb begin
    case (ctrl.op)
      OP_COL: begin
        add_a = x_acc_r;
        add_b = ADV_W'(side_r);
      end
      OP_ROW: begin
        add_a = y_acc_r;
        add_b = ADV_W'(side_r);
      end
      OP_CUR: begin
        add_a = cursor_r;
        add_b = advance;
      end
      default: begin
        add_a = x_acc_r;
        add_b = '0;
      end
    endcase
  end

  sgtr_sat_add #(
    .COORD_BITS (COORD_BITS)
  ) u_add (
    .a   (add_a),
    .b   (add_b),
    .sum (add_sum)
  );

  assign start_x = in_ch.first_of_text ? in_ch.origin_x : cursor_r;
  assign emit    = ctrl.step && rem_r[0];

  always_comb begin
    cursor_nxt    = cursor_r;
    x_acc_nxt     = x_acc_r;
    y_acc_nxt     = y_acc_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (stat.accept) begin
      cursor_nxt = start_x;
      x_acc_nxt  = start_x;
      y_acc_nxt  = in_ch.origin_y;
      rem_nxt    = (in_ch.pixel_scale == '0) ? '0 : glyph_mask;
    end
    if (ctrl.step) begin
      x_acc_nxt = add_sum;
      rem_nxt   = rem_r >> 1;
    end
    if (ctrl.row_adv) begin
      y_acc_nxt = add_sum;
      x_acc_nxt = cursor_r;
    end
    if (ctrl.cursor_upd) begin
      cursor_nxt = add_sum;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_acc_r <= x_acc_nxt;
    y_acc_r <= y_acc_nxt;
    rem_r   <= rem_nxt;
    if (stat.accept) begin
      side_r  <= in_ch.pixel_scale;
      color_r <= in_ch.ink_color;
    end
    if (emit) begin
      out_x_r     <= x_acc_r;
      out_y_r     <= y_acc_r;
      out_side_r  <= side_r;
      out_color_r <= color_r;
      out_last_r  <= (rem_r[DOTS-1:1] == '0);
    end
  end

  assign in_ch.ready         = ctrl.in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.rect_x       = out_x_r;
  assign out_ch.rect_y       = out_y_r;
  assign out_ch.rect_side    = out_side_r;
  assign out_ch.rect_color   = out_color_r;
  assign out_ch.last_of_char = out_last_r;

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    stat.accept |=> !in_ch.ready
  ) else $error("Input stayed ready after a transaction was accepted.");

  a_no_overwrite: assert property (
    @(posedge clk) disable iff (!rst_n)
    ctrl.step |-> (!out_valid_r || out_ch.ready)
  ) else $error("Dot scan advanced while a square was still waiting.");

  a_scan_drained: assert property (
    @(posedge clk) disable iff (!rst_n)
    ctrl.cursor_upd |-> (rem_r == '0)
  ) else $error("Cursor advanced before all dots of the glyph were scanned.");

  a_cursor_hold: assert property (
    @(posedge clk) disable iff (!rst_n)
    (!stat.accept && !ctrl.cursor_upd) |=> $stable(cursor_r)
  ) else $error("Cursor changed outside of a load or an advance.");

endmodule
